// File: rtl/sorted_array_insert_delete_defines.svh
// Assertion helpers for the sorted table block.
`ifndef SORTED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define SORTED_ARRAY_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sai_pkg.sv
package sai_pkg;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int RIDX_W   = 6;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_DEL,
      ST_READ,
      ST_OUT
   } state_type;

endpackage

// File: rtl/sai_req_if.sv
interface sai_req_if;
   logic                         valid;
   logic                         ready;
   logic [sai_pkg::FUNC_W-1:0]   func;
   logic signed [sai_pkg::KEY_W-1:0] key_value;
   logic [sai_pkg::RIDX_W-1:0]   read_index;

   modport source (output valid, func, key_value, read_index, input ready);
   modport sink   (input valid, func, key_value, read_index, output ready);
endinterface

// File: rtl/sai_rsp_if.sv
interface sai_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sai_pkg::STATUS_W-1:0]   status;
   logic [sai_pkg::POS_W-1:0]      position;
   logic signed [sai_pkg::KEY_W-1:0] read_value;
   logic [sai_pkg::COUNT_W-1:0]    entry_count;

   modport source (output valid, status, position, read_value, entry_count, input ready);
   modport sink   (input valid, status, position, read_value, entry_count, output ready);
endinterface

// File: rtl/sorted_array_insert_delete.sv
// Sorted table of signed 32-bit values, kept in ascending order, with an entry count.
// req_chan carries one transaction per operation: func (insert, delete first match,
// read at read_index), key_value and read_index. rsp_chan returns exactly one
// transaction per request: status, position, read_value and the new entry_count.
// The table sits in a single-port-write, single-port-read RAM with registered read
// data; a small sequencer walks it one entry per cycle: insert walks down from the
// top entry to the insert position, delete scans the whole table, and read and any
// refused or unused operation skip the walk.
// A new request is taken only once the previous one has been handed to the
// response register. That register lets the next request start while a response
// still waits; a stalled rsp_chan holds the response, and the following one waits
// in the sequencer until the register frees up.
// Reset (synchronous, active high) empties the table by clearing the count; the
// RAM contents are not cleared, no clearing pass is needed.
`include "sorted_array_insert_delete_defines.svh"

module sorted_array_insert_delete #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   sai_req_if.sink   req_chan,
   sai_rsp_if.source rsp_chan
);
   import sai_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > RIDX_W) ? CW : RIDX_W;

   // table RAM
   logic [KEY_W-1:0] table_ff [CAPACITY];
   logic [KEY_W-1:0] mem_rd_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [AW-1:0]    mem_ra;
   logic [KEY_W-1:0] mem_wd;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;     // scan pointer
   logic [AW-1:0]    at_ff, at_in;       // delete hit index
   logic             found_ff, found_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // pending result, waiting for the response register
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AW-1:0]       res_pos_ff, res_pos_in;
   logic [KEY_W-1:0]    res_rval_ff, res_rval_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [KEY_W-1:0]    rsp_rval_ff, rsp_rval_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic req_take;
   logic hit;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_ff[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= table_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      at_ff         <= at_in;
      found_ff      <= found_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_rval_ff   <= res_rval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_rval_ff   <= rsp_rval_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      at_in         = at_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_rval_in   = res_rval_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rval_in   = rsp_rval_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_wa        = AW'(idx_ff);
      mem_wd        = mem_rd_ff;
      mem_ra        = '0;
      hit           = 1'b0;

      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               key_in        = req_chan.key_value;
               idx_in        = '0;
               found_in      = 1'b0;
               res_status_in = STATUS_DONE;
               res_pos_in    = '0;
               res_rval_in   = '0;
               state_in      = ST_OUT;
               case (req_chan.func)
                  FUNC_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        // walk down from the top entry
                        idx_in   = count_ff;
                        mem_ra   = AW'(count_ff - 1'b1);
                        state_in = ST_INS;
                     end
                  end
                  FUNC_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        mem_ra   = '0;
                        state_in = ST_DEL;
                     end
                  end
                  FUNC_READ: begin
                     if (CMP_W'(req_chan.read_index) < CMP_W'(count_ff)) begin
                        mem_ra     = AW'(req_chan.read_index);
                        res_pos_in = AW'(req_chan.read_index);
                        state_in   = ST_READ;
                     end else begin
                        res_status_in = STATUS_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS: begin
            // mem_rd_ff holds entry idx-1; it either moves up to idx or key lands at idx
            mem_we = 1'b1;
            mem_ra = AW'(idx_ff - 2'd2);
            if (idx_ff == '0 || $signed(mem_rd_ff) < $signed(key_ff)) begin
               mem_wd     = key_ff;
               res_pos_in = AW'(idx_ff);
               count_in   = CW'(count_ff + 1'b1);
               state_in   = ST_OUT;
            end else begin
               idx_in = CW'(idx_ff - 1'b1);
            end
         end

         ST_DEL: begin
            // mem_rd_ff holds entry idx; after a hit every later entry moves down
            mem_ra = AW'(idx_ff + 1'b1);
            mem_wa = AW'(idx_ff - 1'b1);
            mem_we = found_ff;
            hit    = !found_ff && (mem_rd_ff == key_ff);
            if (hit) begin
               found_in = 1'b1;
               at_in    = AW'(idx_ff);
            end
            if (CW'(idx_ff + 1'b1) == count_ff) begin
               state_in = ST_OUT;
               if (found_ff || hit) begin
                  count_in   = CW'(count_ff - 1'b1);
                  res_pos_in = found_ff ? at_ff : AW'(idx_ff);
               end else begin
                  res_status_in = STATUS_NOT_FOUND;
               end
            end else begin
               idx_in = CW'(idx_ff + 1'b1);
            end
         end

         ST_READ: begin
            res_rval_in = mem_rd_ff;
            state_in    = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = POS_W'(res_pos_ff);
               rsp_rval_in   = res_rval_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.position    = rsp_pos_ff;
   assign rsp_chan.read_value  = rsp_rval_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // count never passes the table size
   `SAI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "entry count above capacity")

   // the RAM is written only while a shift is in progress
   `SAI_ASSERT_NOW(a_write_in_shift, clock, reset, mem_we, (state_ff == ST_INS) || (state_ff == ST_DEL), "table write outside insert or delete")

   // insert into a full table goes straight to the response with a full flag
   `SAI_ASSERT_NEXT(a_full_refused, clock, reset, req_take && (req_chan.func == FUNC_INSERT) && (count_ff == CW'(CAPACITY)), (state_ff == ST_OUT) && (res_status_ff == STATUS_FULL) && $stable(count_ff), "full insert not refused")

endmodule
